FILE: sv/xyf_pkg.sv
// ----------------------------------------------------------------------------
// XY exponential follower package
// Shared types, widths and the decay base table for the follower with settle.
// ----------------------------------------------------------------------------
`default_nettype none

package xyf_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int MUL_W = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam int FRAC_BITS_DEF = 8;
  localparam int ALPHA_BITS_DEF = 16;
  localparam int ELAPSED_BITS_DEF = 12;

  localparam int DECAY_N = 16;
  localparam logic [MUL_W-1:0] DECAY_BASE0 = 32'd4290143503;

  localparam logic KIND_AIM = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic load_aim;
    logic start;
    logic decay;
    logic alpha;
    logic mul_x;
    logic mul_y;
    logic sq_x;
    logic sq_y;
    logic settle;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic decay_last;
  } stat_t;

  // Base k is 0.75^(2^k / 256) in Q0.32, each one the truncated square of the last.
  function automatic logic [DECAY_N*MUL_W-1:0] decay_bases();
    logic [DECAY_N*MUL_W-1:0] t;
    logic [PROD_W-1:0] b;
    t = '0;
    b = PROD_W'(DECAY_BASE0);
    for (int i = 0; i < DECAY_N; i++) begin
      t[i*MUL_W +: MUL_W] = b[MUL_W-1:0];
      b = (b * b) >> MUL_W;
    end
    return t;
  endfunction

  localparam logic [DECAY_N*MUL_W-1:0] DECAY_BASES = decay_bases();

endpackage

`default_nettype wire

FILE: sv/xyf_ctrl.sv
// ----------------------------------------------------------------------------
// XY exponential follower controller
// Sequences the decay loop, the axis moves, the settle test and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module xyf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           kind,
  output logic           out_valid,
  input  logic           out_ready,
  input  xyf_pkg::stat_t stat,
  output xyf_pkg::cmd_t  cmd
);
  import xyf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECAY  = 9'b000000010,
    S_ALPHA  = 9'b000000100,
    S_MULX   = 9'b000001000,
    S_MULY   = 9'b000010000,
    S_SQX    = 9'b000100000,
    S_SQY    = 9'b001000000,
    S_SETTLE = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_AIM) begin
            cmd.load_aim = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_next = stat.active ? S_DECAY : S_OUT;
          end
        end
      end
      S_DECAY: begin
        cmd.decay = 1'b1;
        if (stat.decay_last) begin
          state_next = S_ALPHA;
        end
      end
      S_ALPHA: begin
        cmd.alpha = 1'b1;
        state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y = 1'b1;
        state_next = S_SETTLE;
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> slot_free)
    else $error("output register loaded while a transfer is pending");

  a_step_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_STEP) |=> !in_ready)
    else $error("input taken while a step item is still in work");

  a_decay_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECAY && !stat.decay_last) |=> state == S_DECAY)
    else $error("decay loop left before its last bit");

endmodule

`default_nettype wire

FILE: sv/xyf_dp.sv
// ----------------------------------------------------------------------------
// XY exponential follower datapath
// Holds aim and position, forms alpha bit-serially and moves both axes on one
// shared 32 by 32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module xyf_dp #(
  parameter int FRAC_BITS    = xyf_pkg::FRAC_BITS_DEF,
  parameter int ALPHA_BITS   = xyf_pkg::ALPHA_BITS_DEF,
  parameter int ELAPSED_BITS = xyf_pkg::ELAPSED_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  xyf_pkg::cmd_t                       cmd,
  output xyf_pkg::stat_t                      stat,
  input  logic signed [xyf_pkg::COORD_W-1:0]  aim_x,
  input  logic signed [xyf_pkg::COORD_W-1:0]  aim_y,
  input  logic        [ELAPSED_BITS-1:0]      elapsed,
  output logic                                moved,
  output logic signed [xyf_pkg::COORD_W-1:0]  out_x,
  output logic signed [xyf_pkg::COORD_W-1:0]  out_y
);
  import xyf_pkg::*;

  localparam int KW = $clog2(ELAPSED_BITS);
  localparam logic [KW-1:0] K_LAST = KW'(ELAPSED_BITS - 1);
  localparam logic [DIST_W+1:0] SETTLE_LIM = (DIST_W + 2)'(1) << (2 * FRAC_BITS);

  logic signed [COORD_W-1:0] goal_x;
  logic signed [COORD_W-1:0] goal_y;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic                      has_goal;
  logic                      at_rest;
  logic                      moved_r;

  logic [ELAPSED_BITS-1:0] el;
  logic [KW-1:0]           k;
  logic [MUL_W-1:0]        p;
  logic                    p_one;
  logic [ALPHA_BITS:0]     alpha;
  logic [DIFF_W-1:0]       mag_x;
  logic [DIFF_W-1:0]       mag_y;
  logic                    neg_x;
  logic                    neg_y;
  logic [DIFF_W-1:0]       step_x;
  logic [DIFF_W-1:0]       step_y;
  logic [SQ_W-1:0]         sq_x;
  logic [SQ_W-1:0]         sq_y;

  logic [MUL_W-1:0]  base;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [MUL_W:0]    one_minus_p;
  logic [DIFF_W-1:0] d_x;
  logic [DIFF_W-1:0] d_y;
  logic [DIST_W-1:0] sq_sum;
  logic              settle_hit;
  logic [DIFF_W-1:0] pos_x_ext;
  logic [DIFF_W-1:0] pos_y_ext;
  logic [DIFF_W-1:0] new_x;
  logic [DIFF_W-1:0] new_y;

  assign stat.active = has_goal && !at_rest;
  assign stat.decay_last = (k == K_LAST);

  assign base = DECAY_BASES[{k, 5'd0} +: MUL_W];

  always_comb begin
    mul_a = p;
    mul_b = base;
    if (cmd.mul_x) begin
      mul_a = MUL_W'(mag_x);
      mul_b = MUL_W'(alpha);
    end else if (cmd.mul_y) begin
      mul_a = MUL_W'(mag_y);
      mul_b = MUL_W'(alpha);
    end else if (cmd.sq_x) begin
      mul_a = MUL_W'(mag_x - step_x);
      mul_b = MUL_W'(mag_x - step_x);
    end else if (cmd.sq_y) begin
      mul_a = MUL_W'(mag_y - step_y);
      mul_b = MUL_W'(mag_y - step_y);
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign one_minus_p = p_one ? '0 : ({1'b1, {MUL_W{1'b0}}} - {1'b0, p});

  assign d_x = {goal_x[COORD_W-1], goal_x} - {pos_x[COORD_W-1], pos_x};
  assign d_y = {goal_y[COORD_W-1], goal_y} - {pos_y[COORD_W-1], pos_y};

  assign sq_sum = DIST_W'(sq_x) + DIST_W'(sq_y);
  assign settle_hit = {sq_sum, 2'b00} < SETTLE_LIM;

  assign pos_x_ext = {pos_x[COORD_W-1], pos_x};
  assign pos_y_ext = {pos_y[COORD_W-1], pos_y};
  assign new_x = neg_x ? (pos_x_ext - step_x) : (pos_x_ext + step_x);
  assign new_y = neg_y ? (pos_y_ext - step_y) : (pos_y_ext + step_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
      pos_x <= '0;
      pos_y <= '0;
      has_goal <= 1'b0;
      at_rest <= 1'b0;
    end else begin
      if (cmd.load_aim) begin
        goal_x <= aim_x;
        goal_y <= aim_y;
        if (!has_goal) begin
          pos_x <= aim_x;
          pos_y <= aim_y;
          has_goal <= 1'b1;
        end
        at_rest <= 1'b0;
      end else if (cmd.settle) begin
        if (settle_hit) begin
          pos_x <= goal_x;
          pos_y <= goal_y;
          at_rest <= 1'b1;
        end else begin
          pos_x <= new_x[COORD_W-1:0];
          pos_y <= new_y[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      el <= elapsed;
      k <= '0;
      p_one <= 1'b1;
      moved_r <= stat.active;
    end
    if (cmd.decay) begin
      k <= k + KW'(1);
      if (el[k]) begin
        p_one <= 1'b0;
        p <= p_one ? base : mul_p[PROD_W-1:MUL_W];
      end
    end
    if (cmd.alpha) begin
      alpha <= one_minus_p[MUL_W -: ALPHA_BITS + 1];
      neg_x <= d_x[DIFF_W-1];
      neg_y <= d_y[DIFF_W-1];
      mag_x <= d_x[DIFF_W-1] ? (~d_x + DIFF_W'(1)) : d_x;
      mag_y <= d_y[DIFF_W-1] ? (~d_y + DIFF_W'(1)) : d_y;
    end
    if (cmd.mul_x) begin
      step_x <= mul_p[ALPHA_BITS +: DIFF_W];
    end
    if (cmd.mul_y) begin
      step_y <= mul_p[ALPHA_BITS +: DIFF_W];
    end
    if (cmd.sq_x) begin
      sq_x <= mul_p[SQ_W-1:0];
    end
    if (cmd.sq_y) begin
      sq_y <= mul_p[SQ_W-1:0];
    end
    if (cmd.load_out) begin
      moved <= moved_r;
      out_x <= pos_x;
      out_y <= pos_y;
    end
  end

  a_rest_on_goal: assert property (@(posedge clk) disable iff (rst)
    at_rest |-> (pos_x == goal_x && pos_y == goal_y))
    else $error("resting position differs from the aim");

  a_step_within_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_x |=> step_x <= mag_x)
    else $error("axis step overshoots the aim");

  a_alpha_below_one: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_x |-> !alpha[ALPHA_BITS])
    else $error("alpha reached one");

endmodule

`default_nettype wire

FILE: sv/xy_exponential_follow_with_settle_unit.sv
// ----------------------------------------------------------------------------
// XY exponential follower with settle detection
// Moves a 2D point toward an aim by 1 - 0.75^frames of the gap per step item
// and snaps onto the aim once the remaining squared distance is below 0.25.
// ----------------------------------------------------------------------------
// Aim items are taken one per cycle while no step item is in work and produce no result.
// A moving step item runs through the decay loop, one elapsed bit per cycle, then alpha,
// four passes through the shared 32 by 32 multiplier, the settle test and the output
// state, where it waits for a free output register; a step item when idle or at rest
// goes straight to the output state.
// No new item is taken until a step item has loaded its result.
// Synchronous reset clears aim, position and the flags to zero.
`default_nettype none

module xy_exponential_follow_with_settle_unit #(
  parameter int FRAC_BITS    = xyf_pkg::FRAC_BITS_DEF,
  parameter int ALPHA_BITS   = xyf_pkg::ALPHA_BITS_DEF,
  parameter int ELAPSED_BITS = xyf_pkg::ELAPSED_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [xyf_pkg::COORD_W-1:0] aim_x,
  input  logic signed [xyf_pkg::COORD_W-1:0] aim_y,
  input  logic        [ELAPSED_BITS-1:0]     elapsed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               moved,
  output logic signed [xyf_pkg::COORD_W-1:0] out_x,
  output logic signed [xyf_pkg::COORD_W-1:0] out_y
);
  import xyf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  xyf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  xyf_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .ALPHA_BITS   (ALPHA_BITS),
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .aim_x   (aim_x),
    .aim_y   (aim_y),
    .elapsed (elapsed),
    .moved   (moved),
    .out_x   (out_x),
    .out_y   (out_y)
  );

endmodule

`default_nettype wire

FILE: tb/tb_xy_exponential_follow_with_settle_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the XY exponential follower with settle detection
// Drives aim and step transfers with random gaps and output stalls, predicts
// every step result from an independent model of the smoothing and settle
// rules, and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_xy_exponential_follow_with_settle_unit;

  localparam int COORD_W   = xyf_pkg::COORD_W;
  localparam int FRAC_W    = xyf_pkg::FRAC_BITS_DEF;
  localparam int ALPHA_W   = xyf_pkg::ALPHA_BITS_DEF;
  localparam int EL_W      = xyf_pkg::ELAPSED_BITS_DEF;
  localparam int LATENCY   = EL_W + 8;
  localparam int LIMIT     = 3000;
  localparam int HOLD_LEN  = 400;
  localparam int ITEMS     = 1150;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [EL_W-1:0] span_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam span_t  EL_MAX = '1;

  class follow_tracker;
    typedef struct {
      logic   moved;
      coord_t x;
      coord_t y;
    } position_t;

    coord_t goal_x, goal_y, pos_x, pos_y;
    bit has_goal, resting;
    position_t pending_positions[$];
    int failures;
    int results_seen;

    function new();
      goal_x = '0;
      goal_y = '0;
      pos_x = '0;
      pos_y = '0;
      has_goal = 0;
      resting = 0;
      failures = 0;
      results_seen = 0;
    endfunction

    function logic [ALPHA_W-1:0] alpha_for(span_t el);
      bit [63:0] p, b;
      p = 64'd1 << 32;
      b = 64'(xyf_pkg::DECAY_BASE0);
      for (int k = 0; k < EL_W; k++) begin
        if (el[k]) p = (p * b) >> 32;
        b = (b * b) >> 32;
      end
      return ALPHA_W'(((64'd1 << 32) - p) >> (32 - ALPHA_W));
    endfunction

    function coord_t follow_axis(coord_t pos, coord_t aim, logic [ALPHA_W-1:0] a);
      longint d, mag, stepm;
      d = longint'(aim) - longint'(pos);
      mag = (d < 0) ? -d : d;
      stepm = (mag * longint'(a)) >>> ALPHA_W;
      if (d < 0) return coord_t'(longint'(pos) - stepm);
      return coord_t'(longint'(pos) + stepm);
    endfunction

    function void take_item(logic k, coord_t ax, coord_t ay, span_t el);
      position_t r;
      logic [ALPHA_W-1:0] a;
      longint dx, dy;
      if (k == xyf_pkg::KIND_AIM) begin
        goal_x = ax;
        goal_y = ay;
        if (!has_goal) begin
          pos_x = ax;
          pos_y = ay;
          has_goal = 1;
        end
        resting = 0;
        return;
      end
      r.moved = 1'b0;
      if (has_goal && !resting) begin
        a = alpha_for(el);
        pos_x = follow_axis(pos_x, goal_x, a);
        pos_y = follow_axis(pos_y, goal_y, a);
        dx = longint'(goal_x) - longint'(pos_x);
        dy = longint'(goal_y) - longint'(pos_y);
        if (4 * (dx * dx + dy * dy) < (longint'(1) << (2 * FRAC_W))) begin
          pos_x = goal_x;
          pos_y = goal_y;
          resting = 1;
        end
        r.moved = 1'b1;
      end
      r.x = pos_x;
      r.y = pos_y;
      pending_positions.push_back(r);
    endfunction

    function void check_position(logic m, coord_t x, coord_t y);
      position_t e;
      results_seen++;
      if (pending_positions.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: moved=%0b x=%0d y=%0d", m, x, y);
        return;
      end
      e = pending_positions.pop_front();
      if (m !== e.moved || x !== e.x || y !== e.y) begin
        failures++;
        if (failures <= 10)
          $display({"Mismatch on result %0d: expected moved=%0b x=%0d y=%0d, ",
                    "got moved=%0b x=%0d y=%0d"},
                   results_seen, e.moved, e.x, e.y, m, x, y);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  logic   kind;
  coord_t aim_x;
  coord_t aim_y;
  span_t  elapsed;
  logic   out_valid;
  logic   out_ready;
  logic   moved;
  coord_t out_x;
  coord_t out_y;

  follow_tracker tracker;
  int sent_count;
  int idle_cycles;
  coord_t last_aim_x, last_aim_y;

  xy_exponential_follow_with_settle_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .aim_x(aim_x),
    .aim_y(aim_y),
    .elapsed(elapsed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .moved(moved),
    .out_x(out_x),
    .out_y(out_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(logic k, coord_t ax, coord_t ay, span_t el);
    bit calm;
    calm = (sent_count >= 700 && sent_count < 850);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    aim_x <= ax;
    aim_y <= ay;
    elapsed <= el;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(k, ax, ay, el);
    sent_count++;
    if (k == xyf_pkg::KIND_AIM) begin
      last_aim_x = ax;
      last_aim_y = ay;
    end
    @(negedge clk);
  endtask

  task automatic send_aim(coord_t ax, coord_t ay);
    send_item(xyf_pkg::KIND_AIM, ax, ay, span_t'($urandom));
  endtask

  task automatic send_step(span_t el);
    send_item(xyf_pkg::KIND_STEP, coord_t'($urandom), coord_t'($urandom), el);
  endtask

  function automatic span_t pick_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 35) return span_t'($urandom_range(1, 255));
    if (r < 70) return span_t'($urandom_range(256, 1024));
    if (r < 95) return span_t'($urandom_range(3000, 4095));
    return span_t'($urandom);
  endfunction

  task automatic send_random_aim();
    coord_t nx, ny;
    if ($urandom_range(99) < 60) begin
      nx = last_aim_x + coord_t'(int'($urandom_range(8191)) - 4096);
      ny = last_aim_y + coord_t'(int'($urandom_range(8191)) - 4096);
    end else begin
      nx = coord_t'($urandom);
      ny = coord_t'($urandom);
    end
    send_aim(nx, ny);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_position(moved, out_x, out_y);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : drain
    int hold_left;
    bit hold_done;
    bit calm;
    hold_left = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      calm = (tracker.results_seen >= 300 && tracker.results_seen < 420);
      if (!hold_done && tracker.results_seen >= 150) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    int nsteps;
    tracker = new();
    sent_count = 0;
    idle_cycles = 0;
    last_aim_x = '0;
    last_aim_y = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = xyf_pkg::KIND_AIM;
    aim_x = '0;
    aim_y = '0;
    elapsed = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Steps before any aim, then the first aim which places the position.
    send_step('0);
    send_step(EL_MAX);
    send_aim(C_MAX, C_MIN);
    send_step('0);
    send_step(EL_MAX);
    // Full-range jump followed by steps of assorted lengths.
    send_aim(C_MIN, C_MAX);
    send_step(span_t'(1));
    send_step(EL_MAX);
    send_step(span_t'(2048));
    send_step(span_t'(256));
    repeat (4) send_step(EL_MAX);
    send_aim('0, '0);
    repeat (5) send_step(EL_MAX);
    // Half a pixel away does not settle; just under it does.
    send_aim(coord_t'(128), '0);
    send_step('0);
    send_aim(coord_t'(127), coord_t'(-1));
    send_step('0);
    send_step(span_t'(1));
    send_item(xyf_pkg::KIND_STEP, C_MAX, C_MIN, span_t'(1));

    while (sent_count < ITEMS) begin
      send_random_aim();
      nsteps = $urandom_range(1, 12);
      for (int i = 0; i < nsteps; i++) begin
        if ($urandom_range(99) < 8) send_random_aim();
        send_step(pick_elapsed());
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending_positions.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
